FILE: rtl/mesi_pkg.sv
// ----------------------------------------------------------------------------
// mesi_pkg
// Shared sizes, codes and address helpers for the MESI L1 cache controller.
// ----------------------------------------------------------------------------
`default_nettype none
package mesi_pkg;
	localparam int NUM_SETS   = 64;
	localparam int LINE_WORDS = 8;
	localparam int OFF_W = $clog2(LINE_WORDS);
	localparam int SET_W = $clog2(NUM_SETS);
	localparam int TAG_W = 32 - OFF_W - SET_W;
	localparam int WIDX_W = OFF_W + SET_W;
	localparam int FW_W = OFF_W + 1;

	typedef logic [1:0] mesi_t;
	localparam mesi_t ST_I = 2'd0;
	localparam mesi_t ST_S = 2'd1;
	localparam mesi_t ST_E = 2'd2;
	localparam mesi_t ST_M = 2'd3;

	localparam logic [2:0] ACT_RD    = 3'd0;
	localparam logic [2:0] ACT_WR    = 3'd1;
	localparam logic [2:0] ACT_BUS   = 3'd2;
	localparam logic [2:0] ACT_FILL  = 3'd3;
	localparam logic [2:0] ACT_EVICT = 3'd4;

	localparam logic [1:0] CMD_RD    = 2'd1;
	localparam logic [1:0] CMD_RDX   = 2'd2;
	localparam logic [1:0] CMD_FLUSH = 2'd3;

	localparam logic [7:0] REG_CORE_ID = 8'd0;

	function automatic logic [OFF_W-1:0] a_off(input logic [31:0] a);
		return a[OFF_W-1:0];
	endfunction
	function automatic logic [SET_W-1:0] a_set(input logic [31:0] a);
		return a[OFF_W +: SET_W];
	endfunction
	function automatic logic [TAG_W-1:0] a_tag(input logic [31:0] a);
		return a[31 -: TAG_W];
	endfunction
endpackage
`default_nettype wire

FILE: rtl/mesi_l1_cache_controller_unit.sv
// ----------------------------------------------------------------------------
// mesi_l1_cache_controller_unit
// Direct-mapped L1 cache with MESI snooping, tags, states and data in memories.
// ----------------------------------------------------------------------------
// channel  dir  contents
// s_axis   in   action, addresses, data, bus observation
// m_axis   out  one status beat per input beat
// apb      in   core_id register
// Each beat is handled as a read of the tag, state and data memories,
// then the update and write-back. Next beat is taken when the result is
// out or being taken. arst_n clears states (valid bits) and flags; tag and
// data memories are not cleared. A stalled output holds the block.
`default_nettype none
module mesi_l1_cache_controller_unit import mesi_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// action[2:0] core_addr[34:3] core_wdata[66:35] bus_cmd[68:67]
	// snoop_addr[100:69] snoop_data[132:101] snoop_shared[133] bus_origin[137:134]
	input  wire logic [143:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// core_done[0] core_rdata[32:1] drive_valid[33] drive_addr[65:34]
	// drive_data[97:66] assert_shared[98] bus_busy[99] req_pending[100]
	// req_exclusive[101] req_addr[133:102] evict_pending[134]
	output logic [135:0]      m_axis_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	logic [3:0] core_id_q;
	logic [TAG_W-1:0] tag_mem [NUM_SETS];
	logic [31:0] data_mem [NUM_SETS*LINE_WORDS];
	logic [NUM_SETS-1:0][1:0] st_q;

	logic miss_valid_q, miss_excl_q, fill_wait_q, fill_sh_q, tcd_q, evw_q, fa_q;
	logic [31:0] miss_addr_q, flush_base_q;
	logic [FW_W-1:0] flush_word_q;

	logic busy_s1;
	logic [143:0] in_s1;
	logic [TAG_W-1:0] rtag_s1, mtag_s1;
	mesi_t rst_s1, mst_s1;
	logic [31:0] rdat_s1;

	assign pready = 1'b1;
	assign prdata = {28'd0, core_id_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) core_id_q <= '0;
		else if (psel && penable && pwrite && paddr[2] == REG_CORE_ID[0])
			core_id_q <= pwdata[3:0];
	end

	assign s_axis_tready = !busy_s1 && (!m_axis_tvalid || m_axis_tready);
	wire acc = s_axis_tvalid && s_axis_tready;

	// read address select: data from flush, fill or core
	wire [2:0]  i_act = s_axis_tdata[2:0];
	wire [31:0] i_ca  = s_axis_tdata[34:3];
	wire [31:0] i_ba  = s_axis_tdata[100:69];
	wire [31:0] rd_a  = (i_act == ACT_BUS) ? (fa_q ? {flush_base_q[31:OFF_W],
		flush_word_q[OFF_W-1:0]} : i_ba) : i_ca;

	always_ff @(posedge clk) begin
		if (acc) begin
			in_s1   <= s_axis_tdata;
			rtag_s1 <= tag_mem[a_set(rd_a)];
			rdat_s1 <= data_mem[rd_a[WIDX_W-1:0]];
			mtag_s1 <= tag_mem[a_set(miss_addr_q)];
			rst_s1  <= st_q[a_set(rd_a)];
			mst_s1  <= st_q[a_set(miss_addr_q)];
		end
	end

	// stage 2 evaluation
	logic [2:0] act; logic [31:0] ca, wd, ba, bd; logic [1:0] cmd; logic bsh;
	logic [3:0] org;
	assign act = in_s1[2:0]; assign ca = in_s1[34:3]; assign wd = in_s1[66:35];
	assign cmd = in_s1[68:67]; assign ba = in_s1[100:69]; assign bd = in_s1[132:101];
	assign bsh = in_s1[133]; assign org = in_s1[137:134];

	logic n_mv, n_mx, n_fw, n_fs, n_tcd, n_evw, n_fa;
	logic [31:0] n_ma, n_fb; logic [FW_W-1:0] n_fwd;
	logic st_we; logic [SET_W-1:0] st_set; mesi_t st_val;
	logic tg_we; logic [SET_W-1:0] tg_set; logic [TAG_W-1:0] tg_val;
	logic dm_we; logic [WIDX_W-1:0] dm_idx; logic [31:0] dm_val;
	logic o_done, o_dv, o_sh; logic [31:0] o_rd, o_da, o_dd;
	logic [SET_W-1:0] s; mesi_t st; logic miss_is, post_ok;
	logic [TAG_W-1:0] mtag_eff; mesi_t mst;

	always_comb begin
		n_mv = miss_valid_q; n_mx = miss_excl_q; n_fw = fill_wait_q; n_fs = fill_sh_q;
		n_tcd = tcd_q; n_evw = evw_q; n_fa = fa_q; n_ma = miss_addr_q;
		n_fb = flush_base_q; n_fwd = flush_word_q;
		st_we = 1'b0; st_set = '0; st_val = ST_I;
		tg_we = 1'b0; tg_set = '0; tg_val = '0;
		dm_we = 1'b0; dm_idx = '0; dm_val = '0;
		o_done = 1'b0; o_dv = 1'b0; o_sh = 1'b0; o_rd = '0; o_da = '0; o_dd = '0;
		s = a_set(ca); st = rst_s1;
		miss_is = miss_valid_q && miss_addr_q == ca;
		post_ok = !evw_q && !fa_q;
		case (act)
			ACT_RD: begin
				if (st != ST_I && rtag_s1 == a_tag(ca)) begin
					if (miss_is) n_mv = 1'b0;
					o_done = 1'b1; o_rd = rdat_s1; n_tcd = 1'b0;
				end else if (st == ST_M) begin
					if (post_ok) begin
						n_evw = 1'b1; n_fwd = '0;
						n_fb = {rtag_s1, s, {OFF_W{1'b0}}};
					end
				end else if (!miss_is) begin
					if (!tcd_q) n_tcd = 1'b1;
					else begin
						n_mx = 1'b0; n_mv = 1'b1; n_ma = ca; n_fs = 1'b0; n_tcd = 1'b0;
					end
				end
			end
			ACT_WR: begin
				if ((st == ST_M || st == ST_E) && rtag_s1 == a_tag(ca)) begin
					if (miss_is) n_mv = 1'b0;
					dm_we = 1'b1; dm_idx = ca[WIDX_W-1:0]; dm_val = wd;
					st_we = 1'b1; st_set = s; st_val = ST_M;
					o_done = 1'b1; n_tcd = 1'b0;
				end else if (st == ST_M) begin
					if (post_ok) begin
						n_evw = 1'b1; n_fwd = '0;
						n_fb = {rtag_s1, s, {OFF_W{1'b0}}};
					end
				end else if (!miss_excl_q && !tcd_q) begin
					n_tcd = 1'b1;
				end else begin
					if (!miss_excl_q && !miss_is) n_tcd = 1'b0;
					n_mx = 1'b1;
					if (!miss_is) begin n_mv = 1'b1; n_ma = ca; end
				end
			end
			ACT_BUS: begin
				if (fa_q) begin
					s = a_set(flush_base_q);
					o_dv = 1'b1; o_sh = 1'b1; o_dd = rdat_s1;
					o_da = flush_base_q + 32'(flush_word_q);
					n_fwd = flush_word_q + 1'b1;
					if (n_fwd >= FW_W'(LINE_WORDS)) begin
						n_fa = 1'b0;
						if (rst_s1 == ST_M) begin st_we = 1'b1; st_set = s; st_val = ST_I; end
					end
				end else if (cmd == CMD_RD || cmd == CMD_RDX) begin
					s = a_set(ba);
					if (org != core_id_q && st != ST_I && rtag_s1 == a_tag(ba)) begin
						if (cmd == CMD_RD && st != ST_M) o_sh = 1'b1;
						st_set = s; st_val = (cmd == CMD_RD) ? ST_S : ST_I;
						if (st == ST_M) begin
							n_fa = 1'b1; n_fb = {ba[31:OFF_W], {OFF_W{1'b0}}};
							n_fwd = '0; st_we = 1'b1;
						end else if (st == ST_E || cmd == CMD_RDX) st_we = 1'b1;
					end
				end else if (cmd == CMD_FLUSH) begin
					if (bsh) n_fs = 1'b1;
					if (fill_wait_q && miss_valid_q && ba[31:OFF_W] == miss_addr_q[31:OFF_W]) begin
						s = a_set(ba);
						dm_we = 1'b1; dm_idx = ba[WIDX_W-1:0]; dm_val = bd;
						if (a_off(ba) == OFF_W'(LINE_WORDS-1)) begin
							tg_we = 1'b1; tg_set = s; tg_val = a_tag(ba);
							n_fw = 1'b0; st_we = 1'b1; st_set = s;
							if (miss_excl_q) begin st_val = ST_M; n_mx = 1'b0; end
							else st_val = n_fs ? ST_S : ST_E;
						end
					end
				end
			end
			ACT_FILL: if (miss_valid_q) n_fw = 1'b1;
			ACT_EVICT: if (evw_q && !fa_q) begin n_evw = 1'b0; n_fa = 1'b1; n_fwd = '0; end
			default: ;
		endcase
		// status uses post-update state; forward this beat's tag/state writes
		mtag_eff = (tg_we && tg_set == a_set(n_ma)) ? tg_val :
			(n_ma == miss_addr_q ? mtag_s1 : rtag_s1);
		mst = (st_we && st_set == a_set(n_ma)) ? st_val :
			(n_ma == miss_addr_q ? mst_s1 : rst_s1);
	end

	wire have = mtag_eff == a_tag(n_ma) && (n_mx ? (mst == ST_M || mst == ST_E) : mst != ST_I);
	wire rp = n_mv && !n_fw && !have;

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			if (tg_we) tag_mem[tg_set] <= tg_val;
			if (dm_we) data_mem[dm_idx] <= dm_val;
			m_axis_tdata <= {1'b0, n_evw, rp ? n_ma : 32'd0, rp & n_mx, rp, n_fa, o_sh,
				o_dd, o_da, o_dv, o_rd, o_done};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0; m_axis_tvalid <= 1'b0; st_q <= '0;
			miss_valid_q <= 1'b0; miss_excl_q <= 1'b0; fill_wait_q <= 1'b0;
			fill_sh_q <= 1'b0; tcd_q <= 1'b0; evw_q <= 1'b0; fa_q <= 1'b0;
			miss_addr_q <= '0; flush_base_q <= '0; flush_word_q <= '0;
		end else begin
			busy_s1 <= acc;
			if (busy_s1) m_axis_tvalid <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			if (busy_s1) begin
				if (st_we) st_q[st_set] <= st_val;
				miss_valid_q <= n_mv; miss_excl_q <= n_mx; fill_wait_q <= n_fw;
				fill_sh_q <= n_fs; tcd_q <= n_tcd; evw_q <= n_evw; fa_q <= n_fa;
				miss_addr_q <= n_ma; flush_base_q <= n_fb; flush_word_q <= n_fwd;
			end
		end
	end

	wire unused_ok = ^{s_axis_tdata[143:138], in_s1[143:138]};

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !s_axis_tready) else $error("accept during update");
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |=> m_axis_tvalid) else $error("result missing");
	a_flush_word: assert property (@(posedge clk) disable iff (!arst_n)
		fa_q |-> flush_word_q < FW_W'(LINE_WORDS))
		else $error("flush word range");
endmodule
`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MESI L1 cache controller: directed beats walk
// a miss, a fill, hits and a snoop with intervention, then random traffic
// steered toward complete fills, conflicts, writebacks and snoops. Every
// status beat is checked field by field against a beat-level predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	import mesi_pkg::*;

	localparam logic [2:0] ACT_NOP = 3'd5;
	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam int LIMIT = 300000;

	typedef struct packed {
		logic [5:0]  pad;
		logic [3:0]  origin;
		logic        shared;
		logic [31:0] bdata;
		logic [31:0] baddr;
		logic [1:0]  cmd;
		logic [31:0] wdata;
		logic [31:0] caddr;
		logic [2:0]  act;
	} beat_t;

	typedef struct packed {
		logic        pad;
		logic        evict;
		logic [31:0] raddr;
		logic        rexcl;
		logic        rpend;
		logic        busy;
		logic        shared;
		logic [31:0] ddata;
		logic [31:0] daddr;
		logic        dvalid;
		logic [31:0] rdata;
		logic        done;
	} status_t;

	class cache_sb;
		bit [3:0]  my_id;
		bit [22:0] tags[64];
		mesi_t     lstate[64];
		bit [31:0] words[512];
		bit        written[512];
		bit        miss_v, miss_x, fill_w, fill_sh, tcd, ev_w, fl_act;
		bit [31:0] miss_a, fl_base;
		int        fl_word;
		status_t   expq[$];
		int        errors;

		function new();
			for (int i = 0; i < 64; i++) lstate[i] = ST_I;
		endfunction

		function void post_wb(bit [5:0] s);
			if (!ev_w && !fl_act) begin
				ev_w = 1;
				fl_base = {tags[s], s, 3'b000};
				fl_word = 0;
			end
		endfunction

		function void note(beat_t b);
			status_t o;
			bit [5:0] s;
			bit [22:0] t;
			bit hit_m, go, have;
			o = '0;
			s = b.caddr[8:3];
			t = b.caddr[31:9];
			hit_m = miss_v && miss_a == b.caddr;
			case (b.act)
				ACT_RD: begin
					if (lstate[s] != ST_I && tags[s] == t) begin
						if (hit_m) miss_v = 0;
						o.done = 1;
						o.rdata = words[{s, b.caddr[2:0]}];
						tcd = 0;
					end else if (lstate[s] == ST_M) post_wb(s);
					else if (!hit_m) begin
						if (!tcd) tcd = 1;
						else begin
							miss_x = 0; miss_v = 1; miss_a = b.caddr;
							fill_sh = 0; tcd = 0;
						end
					end
				end
				ACT_WR: begin
					if ((lstate[s] == ST_M || lstate[s] == ST_E) && tags[s] == t) begin
						if (hit_m) miss_v = 0;
						words[{s, b.caddr[2:0]}] = b.wdata;
						written[{s, b.caddr[2:0]}] = 1;
						lstate[s] = ST_M;
						tcd = 0;
						o.done = 1;
					end else if (lstate[s] == ST_M) post_wb(s);
					else begin
						go = 1;
						if (!miss_x) begin
							if (!tcd) begin
								tcd = 1; go = 0;
							end else if (!hit_m) tcd = 0;
						end
						if (go) begin
							miss_x = 1;
							if (!hit_m) begin
								miss_v = 1; miss_a = b.caddr;
							end
						end
					end
				end
				ACT_BUS: begin
					if (fl_act) begin
						s = fl_base[8:3];
						o.dvalid = 1;
						o.daddr = fl_base + fl_word;
						o.ddata = words[{s, fl_word[2:0]}];
						o.shared = 1;
						fl_word++;
						if (fl_word >= LINE_WORDS) begin
							fl_act = 0;
							if (lstate[s] == ST_M) lstate[s] = ST_I;
						end
					end else if (b.cmd == CMD_RD || b.cmd == CMD_RDX) begin
						s = b.baddr[8:3];
						if (b.origin != my_id && lstate[s] != ST_I
								&& tags[s] == b.baddr[31:9]) begin
							if (b.cmd == CMD_RD && lstate[s] != ST_M) o.shared = 1;
							if (lstate[s] == ST_M) begin
								fl_act = 1;
								fl_base = {b.baddr[31:3], 3'b000};
								fl_word = 0;
								lstate[s] = (b.cmd == CMD_RD) ? ST_S : ST_I;
							end else if (lstate[s] == ST_E)
								lstate[s] = (b.cmd == CMD_RD) ? ST_S : ST_I;
							else if (b.cmd == CMD_RDX) lstate[s] = ST_I;
						end
					end else if (b.cmd == CMD_FLUSH) begin
						if (b.shared) fill_sh = 1;
						if (fill_w && miss_v && b.baddr[31:3] == miss_a[31:3]) begin
							s = b.baddr[8:3];
							words[{s, b.baddr[2:0]}] = b.bdata;
							written[{s, b.baddr[2:0]}] = 1;
							if (b.baddr[2:0] == 3'd7) begin
								tags[s] = b.baddr[31:9];
								fill_w = 0;
								if (miss_x) begin
									lstate[s] = ST_M; miss_x = 0;
								end else lstate[s] = fill_sh ? ST_S : ST_E;
							end
						end
					end
				end
				ACT_FILL: if (miss_v) fill_w = 1;
				ACT_EVICT: begin
					if (ev_w && !fl_act) begin
						ev_w = 0; fl_act = 1; fl_word = 0;
					end
				end
				default: ;
			endcase
			o.busy = fl_act;
			if (miss_v && !fill_w) begin
				s = miss_a[8:3];
				have = tags[s] == miss_a[31:9] && (miss_x ?
					(lstate[s] == ST_M || lstate[s] == ST_E) : lstate[s] != ST_I);
				if (!have) begin
					o.rpend = 1; o.rexcl = miss_x; o.raddr = miss_a;
				end
			end
			o.evict = ev_w;
			expq.push_back(o);
		endfunction

		function void cmp(string nm, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t mismatch %s: expected %h actual %h", $time, nm, e, a);
			end
		endfunction

		function void check(status_t a);
			status_t e;
			if (expq.size() == 0) begin
				errors++;
				$display("%0t unexpected beat: expected none actual %h", $time, a);
				return;
			end
			e = expq.pop_front();
			cmp("core_done", e.done, a.done);
			cmp("core_rdata", e.rdata, a.rdata);
			cmp("drive_valid", e.dvalid, a.dvalid);
			cmp("drive_addr", e.daddr, a.daddr);
			cmp("drive_data", e.ddata, a.ddata);
			cmp("assert_shared", e.shared, a.shared);
			cmp("bus_busy", e.busy, a.busy);
			cmp("req_pending", e.rpend, a.rpend);
			cmp("req_exclusive", e.rexcl, a.rexcl);
			cmp("req_addr", e.raddr, a.raddr);
			cmp("evict_pending", e.evict, a.evict);
		endfunction
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
	logic [143:0] s_axis_tdata;
	logic [135:0] m_axis_tdata;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	int cyc;
	int fill_ofs;
	bit [28:0] fill_line;
	bit [31:0] last_core;
	cache_sb sb;

	mesi_l1_cache_controller_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function bit quiet();
		return cyc >= 300 && cyc < 1000;
	endfunction

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk) begin
		if (cyc >= 1500 && cyc < 1800) m_axis_tready <= 1'b0;
		else if (quiet()) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom % 100) >= 23;
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);

	task automatic reg_write(logic [2:0] a, logic [31:0] d);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.my_id = d[3:0];
	endtask

	task automatic send(beat_t b);
		if (!quiet() && ($urandom % 100) < 23) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.note(b);
	endtask

	task automatic send_f(logic [2:0] act, logic [31:0] ca, logic [31:0] wd,
			logic [1:0] cmd, logic [31:0] ba, logic [31:0] bd, logic sh, logic [3:0] org);
		beat_t b;
		b = '{6'd0, org, sh, bd, ba, cmd, wd, ca, act};
		send(b);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.expq.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// small pool of tags and sets so conflicts and snoop hits are common
	function automatic bit [31:0] pool_addr();
		bit [22:0] t;
		bit [5:0] s;
		case ($urandom_range(0, 3))
			0: t = 23'd0;
			1: t = 23'h7FFFFF;
			2: t = 23'd1;
			default: t = 23'($urandom);
		endcase
		if ($urandom_range(0, 9) == 0) t = 23'($urandom);
		case ($urandom_range(0, 3))
			0: s = 6'd0;
			1: s = 6'd63;
			default: s = 6'($urandom_range(0, 3));
		endcase
		return {t, s, 3'($urandom)};
	endfunction

	function automatic beat_t next_beat();
		beat_t b;
		int r;
		bit [5:0] s;
		b.pad = '0;
		b.origin = 4'($urandom);
		b.shared = 1'($urandom);
		b.bdata = $urandom;
		b.wdata = $urandom;
		b.baddr = pool_addr();
		b.cmd = 2'($urandom);
		b.caddr = ($urandom_range(0, 1) && last_core != 0) ? last_core : pool_addr();
		r = $urandom_range(0, 99);
		// restart the word count when no fill waits or the line under fill changes
		if (!sb.fill_w || sb.miss_a[31:3] != fill_line) fill_ofs = 0;
		fill_line = sb.miss_a[31:3];
		if (sb.fl_act) b.act = (r < 75) ? ACT_BUS : 3'($urandom);
		else if (sb.fill_w && sb.miss_v) begin
			b.act = ACT_BUS;
			b.cmd = CMD_FLUSH;
			b.baddr = {sb.miss_a[31:3], 3'(fill_ofs)};
			fill_ofs++;
		end else if (sb.ev_w && r < 50) b.act = ACT_EVICT;
		else if (sb.miss_v && r < 50) b.act = ACT_FILL;
		else if (r < 80) b.act = ($urandom_range(0, 1)) ? ACT_RD : ACT_WR;
		else if (r < 93) begin
			b.act = ACT_BUS;
			b.cmd = ($urandom_range(0, 1)) ? CMD_RD : CMD_RDX;
		end else b.act = 3'($urandom_range(3, 7));
		// a stray flush word must never land on the line being filled
		if (b.act == ACT_BUS && b.cmd == CMD_FLUSH && !sb.fill_w
				&& b.baddr[31:3] == sb.miss_a[31:3])
			b.baddr[31] = ~b.baddr[31];
		if (b.act == ACT_RD) begin
			s = b.caddr[8:3];
			if (sb.lstate[s] != ST_I && sb.tags[s] == b.caddr[31:9]
					&& !sb.written[{s, b.caddr[2:0]}])
				b.act = ACT_NOP;
		end
		if (b.act == ACT_RD || b.act == ACT_WR) last_core = b.caddr;
		return b;
	endfunction

	initial begin
		bit [3:0] ids[4];
		logic [31:0] la;
		sb = new();
		cyc = 0;
		arst_n = 0;
		s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		fill_ofs = 0; fill_line = '0; last_core = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		ids = '{4'd3, 4'd0, 4'd15, 4'($urandom)};

		reg_write(REG_CORE_ID[2:0], 32'd3);
		la = 32'h0000_0010;
		// grants with nothing to act on, and an unused action code
		send_f(ACT_FILL, 32'hFFFFFFFF, 0, CMD_NONE, 0, 0, 0, 0);
		send_f(ACT_EVICT, 0, 0, CMD_NONE, 0, 0, 0, 0);
		send_f(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, CMD_FLUSH, 32'hFFFFFFFF,
			32'hFFFFFFFF, 1, 4'hF);
		// read miss: tag check, then pending, then fill to E
		send_f(ACT_RD, la, 0, CMD_NONE, 0, 0, 0, 0);
		send_f(ACT_RD, la, 0, CMD_NONE, 0, 0, 0, 0);
		send_f(ACT_FILL, 0, 0, CMD_NONE, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++)
			send_f(ACT_BUS, 0, 0, CMD_FLUSH, {la[31:3], 3'(i)}, $urandom, 0, 1);
		send_f(ACT_RD, la, 0, CMD_NONE, 0, 0, 0, 0);
		send_f(ACT_WR, la + 1, 32'hFFFFFFFF, CMD_NONE, 0, 0, 0, 0);
		// own BusRd ignored, remote BusRd on M starts an intervention
		send_f(ACT_BUS, 0, 0, CMD_RD, la, 0, 0, 4'd3);
		send_f(ACT_BUS, 0, 0, CMD_RD, la + 2, 0, 0, 4'd7);
		for (int i = 0; i < 8; i++)
			send_f(ACT_BUS, 0, 0, CMD_RDX, la, 0, 0, 4'd7);
		send_f(ACT_BUS, 0, 0, CMD_RDX, la, 0, 0, 4'd9);
		send_f(ACT_RD, 32'hFFFFFFFF, 0, CMD_NONE, 0, 0, 0, 0);
		drain();

		for (int p = 0; p < 4; p++) begin
			if (p > 0) begin
				reg_write(REG_CORE_ID[2:0], {28'd0, ids[p]});
			end
			for (int n = 0; n < 225; n++) send(next_beat());
			// sender waits for every outstanding beat before moving on
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expq.size() == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
